// ===== design/fdhs_pkg.sv =====
// Shared types, constants and the soft-clip table of the feedback delay block.
// Used by the stream interfaces, fdhs_softclip and the top level.
// No dependencies.
package fdhs_pkg;

  localparam int unsigned SAMPLE_BITS     = 24;
  localparam int unsigned DELAY_FRAC_BITS = 8;
  localparam int unsigned TANH_ENTRIES    = 256;
  localparam int unsigned TANH_IDX_W      = $clog2(TANH_ENTRIES + 1);

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 22;
  localparam int unsigned GAIN_W     = 15;
  localparam logic [GAIN_W-1:0] GAIN_MAX = 15'd31129;

  // Accumulator width of the interpolator (holds 32x a full-scale sample)
  localparam int unsigned ACC_W = SAMPLE_BITS + 5;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [TANH_ENTRIES:0][SAMPLE_BITS-1:0] tanh_tab_t;

  localparam logic signed [ACC_W-1:0] ACC_SMAX = ACC_W'(2 ** (SAMPLE_BITS - 1) - 1);
  localparam logic signed [ACC_W-1:0] ACC_SMIN = -ACC_SMAX - ACC_W'(1);

  // Restoring long division; evaluated only while building the constant table
  function automatic logic [63:0] div_u64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], n[b]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Build tanh(x) at x = 4k/TANH_ENTRIES as (1-t)/(1+t), t = exp(-8/TANH_ENTRIES)^k
  function automatic tanh_tab_t build_tanh();
    logic [63:0]  term;
    logic [63:0]  ratio;
    logic [63:0]  t;
    logic [63:0]  t30;
    logic [63:0]  num;
    logic [63:0]  den;
    logic [63:0]  quo;
    logic [127:0] prod;
    tanh_tab_t    tab;
    term  = 64'd1 << 60;
    ratio = term;
    t     = term;
    // Taylor series of the ratio in Q60
    for (int n = 1; n < 40; n++) begin
      if (term != 64'd0) begin
        term = div_u64(term * 64'd8, 64'(TANH_ENTRIES) * 64'(n));
        if (n[0]) begin
          ratio = ratio - term;
        end else begin
          ratio = ratio + term;
        end
      end
    end
    for (int k = 0; k <= TANH_ENTRIES; k++) begin
      t30    = t >> 30;
      num    = (64'd1 << 30) - t30;
      den    = (64'd1 << 30) + t30;
      quo    = div_u64((num << (SAMPLE_BITS - 1)) + (den >> 1), den);
      tab[k] = quo[SAMPLE_BITS-1:0];
      prod   = {64'd0, t} * {64'd0, ratio};
      t      = prod[123:60];
    end
    return tab;
  endfunction

  localparam tanh_tab_t TANH_TAB = build_tanh();

  // Saturate an accumulator value to one sample
  function automatic sample_t sat_acc(input logic signed [ACC_W-1:0] v);
    sample_t r;
    if (v > ACC_SMAX) begin
      r = ACC_SMAX[SAMPLE_BITS-1:0];
    end else if (v < ACC_SMIN) begin
      r = ACC_SMIN[SAMPLE_BITS-1:0];
    end else begin
      r = v[SAMPLE_BITS-1:0];
    end
    return r;
  endfunction

endpackage

// ===== design/fdhs_in_if.sv =====
// Input sample stream: valid/ready handshake carrying one in_sample per beat.
// Depends on fdhs_pkg.
interface fdhs_in_if;
  import fdhs_pkg::*;

  logic    valid;
  logic    ready;
  sample_t in_sample;

  modport source (output valid, output in_sample, input ready);
  modport sink   (input valid, input in_sample, output ready);
endinterface

// ===== design/fdhs_out_if.sv =====
// Result stream: valid/ready handshake carrying one delayed_sample per beat.
// Depends on fdhs_pkg.
interface fdhs_out_if;
  import fdhs_pkg::*;

  logic    valid;
  logic    ready;
  sample_t delayed_sample;

  modport source (output valid, output delayed_sample, input ready);
  modport sink   (input valid, input delayed_sample, output ready);
endinterface

// ===== design/fdhs_softclip.sv =====
// Table-based tanh soft clipper: odd-symmetric, linear interpolation, holds tanh(4)
// beyond the table. Combinational; depends on fdhs_pkg (TANH_TAB, sat_acc).
module fdhs_softclip (
  input  logic signed [fdhs_pkg::SAMPLE_BITS:0] arg_i,
  output fdhs_pkg::sample_t                     res_o
);
  import fdhs_pkg::*;

  localparam int unsigned MAG_W = SAMPLE_BITS + 2;
  localparam int unsigned FR_W  = MAG_W - TANH_IDX_W;

  logic                          neg;
  logic [MAG_W-1:0]              arg_ext;
  logic [MAG_W-1:0]              mag;
  logic [TANH_IDX_W-1:0]         idx;
  logic [TANH_IDX_W-1:0]         idx_lo;
  logic [FR_W-1:0]               frac;
  logic                          over;
  logic [SAMPLE_BITS-1:0]        y_lo;
  logic [SAMPLE_BITS-1:0]        y_hi;
  logic [SAMPLE_BITS-1:0]        diff;
  logic [SAMPLE_BITS+FR_W-1:0]   step;
  logic [SAMPLE_BITS-1:0]        y_mag;
  logic [ACC_W-1:0]              y_ext;
  logic signed [ACC_W-1:0]       y_s;

  // Split magnitude into table index and fraction
  assign neg     = arg_i[SAMPLE_BITS];
  assign arg_ext = {arg_i[SAMPLE_BITS], arg_i};
  assign mag     = neg ? (~arg_ext + MAG_W'(1)) : arg_ext;
  assign idx     = mag[MAG_W-1:FR_W];
  assign frac    = mag[FR_W-1:0];
  assign over    = (idx >= TANH_IDX_W'(TANH_ENTRIES));
  assign idx_lo  = over ? TANH_IDX_W'(TANH_ENTRIES - 1) : idx;

  // Interpolate between neighboring entries, floor of the step
  assign y_lo  = TANH_TAB[idx_lo];
  assign y_hi  = TANH_TAB[idx_lo + 1'b1];
  assign diff  = y_hi - y_lo;
  assign step  = diff * frac;
  assign y_mag = over ? TANH_TAB[TANH_ENTRIES] : (y_lo + step[FR_W +: SAMPLE_BITS]);

  // Restore the sign
  assign y_ext = {{(ACC_W - SAMPLE_BITS){1'b0}}, y_mag};
  assign y_s   = neg ? -y_ext : y_ext;
  assign res_o = sat_acc(y_s);

endmodule

// ===== design/feedback_delay_hermite_softclip.sv =====
// Feedback delay line with 4-point Hermite fractional read and tanh soft clip.
// Depends on fdhs_pkg, fdhs_in_if, fdhs_out_if and fdhs_softclip.
//
//   Channel  Dir  Handshake      Beat payload
//   in_i     in   valid/ready    in_sample      (Q1.23 signed)
//   out_o    out  valid/ready    delayed_sample (Q1.23 signed, saturated)
//   cfg      in   cfg_we_i only  cfg_idx_i, cfg_data_i (0: delay, 1: gain)
//
// The block takes a new item only after the last one is written back: the
// single memory port takes four tap reads and one write-back, and the Horner
// steps and soft clips share one datapath. The result sits in an output
// register, so the input stays open while it waits; only the next result
// stalls if the previous one is still not taken.
// No clearing pass after reset: a fill mark makes unwritten entries read as zero.
module feedback_delay_hermite_softclip #(
  parameter int unsigned DEPTH = 16384
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [fdhs_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [fdhs_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  fdhs_in_if.sink                            in_i,
  fdhs_out_if.source                         out_o
);
  import fdhs_pkg::*;

  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned F     = DELAY_FRAC_BITS;
  localparam int unsigned POS_W = AW + F + 1;
  localparam int unsigned CW    = (POS_W > CFG_DATA_W) ? POS_W : CFG_DATA_W;
  localparam int unsigned H_W   = ACC_W;
  localparam int unsigned GP_W  = SAMPLE_BITS + GAIN_W + 1;

  localparam logic [CW-1:0] SPAN = CW'(DEPTH) << F;
  localparam logic [CW-1:0] DMIN = CW'(1) << F;
  localparam logic [CW-1:0] DMAX = CW'(DEPTH - 4) << F;
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  localparam logic [CFG_IDX_W-1:0] REG_DELAY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN  = 2'd1;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_POS   = 4'd1;
  localparam logic [3:0] ST_ADR   = 4'd2;
  localparam logic [3:0] ST_RD    = 4'd3;
  localparam logic [3:0] ST_LAST  = 4'd4;
  localparam logic [3:0] ST_COEF  = 4'd5;
  localparam logic [3:0] ST_HORN  = 4'd6;
  localparam logic [3:0] ST_OUT   = 4'd7;
  localparam logic [3:0] ST_GAIN  = 4'd8;
  localparam logic [3:0] ST_CLIP1 = 4'd9;
  localparam logic [3:0] ST_SUM   = 4'd10;
  localparam logic [3:0] ST_CLIP2 = 4'd11;

  // Control state
  logic [3:0]        state_q, state_d;
  logic [1:0]        cnt_q, cnt_d;
  logic [AW-1:0]     wp_q;
  logic              full_q;
  logic              cap_vld_q;
  logic              out_vld_q;
  logic [CW-1:0]     delay_q;
  logic [GAIN_W-1:0] gain_q;

  // Payload
  logic [SAMPLE_BITS-1:0]     delay_store_q [DEPTH];
  sample_t                    rd_data_q;
  logic [AW-1:0]              rd_addr_q;
  logic [AW-1:0]              i0_q;
  logic [F-1:0]               frac_q;
  logic [1:0]                 cap_sel_q;
  logic                       cap_ok_q;
  sample_t                    tap_q [4];
  sample_t                    x_q;
  logic signed [H_W-1:0]      c1_q, c2_q, a_q;
  sample_t                    dly_q;
  sample_t                    out_data_q;
  sample_t                    fbarg_q;
  sample_t                    fb_q;
  logic signed [SAMPLE_BITS:0] sum_q;

  // Combinational
  logic                        in_acc;
  logic                        mem_re;
  logic                        mem_we;
  logic                        out_load;
  logic [CW-1:0]               cfg_dly;
  logic [CW-1:0]               cfg_dly_clamp;
  logic [GAIN_W-1:0]           cfg_gain;
  logic [CW-1:0]               pos_sum;
  logic [CW-1:0]               pos_rp;
  logic signed [H_W-1:0]       y_ext [4];
  logic signed [H_W-1:0]       c3;
  logic signed [H_W-1:0]       horn_add;
  logic signed [H_W+F:0]       horn_prod;
  logic signed [H_W+F:0]       horn_rnd;
  logic signed [H_W-1:0]       half;
  logic signed [GP_W-1:0]      gain_prod;
  logic signed [GP_W-1:0]      gain_rnd;
  logic signed [SAMPLE_BITS:0] clip_arg;
  sample_t                     clip_res;

  assign in_acc    = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == ST_IDLE);
  assign mem_re    = (state_q == ST_RD);
  assign mem_we    = (state_q == ST_CLIP2);
  assign out_load  = (state_q == ST_OUT) && (!out_vld_q || out_o.ready);

  assign out_o.valid          = out_vld_q;
  assign out_o.delayed_sample = out_data_q;

  // Clamp delay and gain on the way into the registers
  assign cfg_dly       = CW'(cfg_data_i);
  assign cfg_dly_clamp = (cfg_dly < DMIN) ? DMIN : ((cfg_dly > DMAX) ? DMAX : cfg_dly);
  assign cfg_gain      = (cfg_data_i[GAIN_W-1:0] > GAIN_MAX) ? GAIN_MAX
                                                             : cfg_data_i[GAIN_W-1:0];

  // Read position behind the write pointer, wrapped into the store span
  assign pos_sum = CW'({wp_q, {F{1'b0}}}) + SPAN - delay_q;
  assign pos_rp  = (pos_sum >= SPAN) ? (pos_sum - SPAN) : pos_sum;

  // Hermite coefficients (doubled)
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      y_ext[k] = {{(H_W - SAMPLE_BITS){tap_q[k][SAMPLE_BITS-1]}}, tap_q[k]};
    end
  end
  assign c3 = (y_ext[3] - y_ext[0]) + H_W'(3) * (y_ext[1] - y_ext[2]);

  // One Horner step per cycle
  always_comb begin
    case (cnt_q)
      2'd0:    horn_add = c2_q;
      2'd1:    horn_add = c1_q;
      default: horn_add = y_ext[1] <<< 1;
    endcase
  end
  assign horn_prod = a_q * $signed({1'b0, frac_q});
  assign horn_rnd  = (horn_prod + (H_W+F+1)'(1 << (F - 1))) >>> F;
  assign half      = (a_q + H_W'(1)) >>> 1;

  // Feedback gain with round half up
  assign gain_prod = dly_q * $signed({1'b0, gain_q});
  assign gain_rnd  = (gain_prod + GP_W'(1 << (GAIN_W - 1))) >>> GAIN_W;

  // Shared soft clipper
  assign clip_arg = (state_q == ST_CLIP1) ? {fbarg_q[SAMPLE_BITS-1], fbarg_q} : sum_q;

  fdhs_softclip u_clip (
    .arg_i (clip_arg),
    .res_o (clip_res)
  );

  // Sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_POS;
        end
      end
      ST_POS:  state_d = ST_ADR;
      ST_ADR: begin
        state_d = ST_RD;
        cnt_d   = 2'd0;
      end
      ST_RD: begin
        cnt_d = cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          state_d = ST_LAST;
        end
      end
      ST_LAST: state_d = ST_COEF;
      ST_COEF: begin
        state_d = ST_HORN;
        cnt_d   = 2'd0;
      end
      ST_HORN: begin
        cnt_d = cnt_q + 2'd1;
        if (cnt_q == 2'd2) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_d = ST_GAIN;
        end
      end
      ST_GAIN:  state_d = ST_CLIP1;
      ST_CLIP1: state_d = ST_SUM;
      ST_SUM:   state_d = ST_CLIP2;
      ST_CLIP2: state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= 2'd0;
      wp_q      <= '0;
      full_q    <= 1'b0;
      cap_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
      delay_q   <= DMIN;
      gain_q    <= '0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      cap_vld_q <= mem_re;
      // Hold the result until the sink takes it
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
      // Advance the write pointer after the write-back
      if (mem_we) begin
        if (wp_q == LAST_ADDR) begin
          wp_q   <= '0;
          full_q <= 1'b1;
        end else begin
          wp_q <= wp_q + 1'b1;
        end
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_DELAY: delay_q <= cfg_dly_clamp;
          REG_GAIN:  gain_q  <= cfg_gain;
          default: ;
        endcase
      end
    end
  end

  // Delay store: one read or one write per cycle, registered read data
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      delay_store_q[wp_q] <= clip_res;
    end
    if (mem_re) begin
      rd_data_q <= delay_store_q[rd_addr_q];
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q <= in_i.in_sample;
    end
    if (state_q == ST_POS) begin
      i0_q   <= pos_rp[F +: AW];
      frac_q <= pos_rp[F-1:0];
    end
    // Walk the four tap addresses starting one before the read position
    if (state_q == ST_ADR) begin
      rd_addr_q <= (i0_q == '0) ? LAST_ADDR : (i0_q - 1'b1);
    end else if (mem_re) begin
      rd_addr_q <= (rd_addr_q == LAST_ADDR) ? '0 : (rd_addr_q + 1'b1);
    end
    // Entries never written since reset read as zero
    if (mem_re) begin
      cap_sel_q <= cnt_q;
      cap_ok_q  <= full_q || (rd_addr_q < wp_q);
    end
    if (cap_vld_q) begin
      tap_q[cap_sel_q] <= cap_ok_q ? rd_data_q : '0;
    end
    if (state_q == ST_COEF) begin
      c1_q <= y_ext[2] - y_ext[0];
      c2_q <= (y_ext[0] <<< 1) - H_W'(5) * y_ext[1] + (y_ext[2] <<< 2) - y_ext[3];
      a_q  <= c3;
    end else if (state_q == ST_HORN) begin
      a_q <= horn_rnd[H_W-1:0] + horn_add;
    end
    if (out_load) begin
      dly_q      <= sat_acc(half);
      out_data_q <= sat_acc(half);
    end
    if (state_q == ST_GAIN) begin
      fbarg_q <= gain_rnd[SAMPLE_BITS-1:0];
    end
    if (state_q == ST_CLIP1) begin
      fb_q <= clip_res;
    end
    if (state_q == ST_SUM) begin
      sum_q <= {x_q[SAMPLE_BITS-1], x_q} + {fb_q[SAMPLE_BITS-1], fb_q};
    end
  end

  // Checks
  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_re && mem_we))
    else $error("delay store read and write in the same cycle");

  a_wp_moves_on_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !mem_we |=> $stable(wp_q))
    else $error("write pointer moved without a write-back");

  a_full_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_q |=> full_q)
    else $error("fill mark dropped");

  a_out_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_o.ready |-> !out_load)
    else $error("pending result overwritten");

  a_accept_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == ST_POS && !mem_we)
    else $error("input beat taken while an item is in flight");

  a_rd_addr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_re |-> {1'b0, rd_addr_q} < (AW+1)'(DEPTH))
    else $error("tap address beyond the store");

endmodule
